### hw/rtl/cht_pkg.sv
// cht_pkg: shared types and constants of the cuckoo hash insert table
// used by cht_ctrl, cht_dp and cuckoo_hash_insert_table
package cht_pkg;

    localparam logic [31:0] EMPTY_KEY = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] hash;
        logic [31:0] value;
    } t_entry;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_LOAD   = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_READ   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_INSERTED = 2'd0,
        STS_FOUND    = 2'd1,
        STS_FAILED   = 2'd2,
        STS_OTHER    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        RS_NONE,
        RS_IDX,
        RS_S1,
        RS_S2,
        RS_ALT,
        RS_CNT
    } t_rsel;

    typedef enum logic [3:0] {
        WS_NONE,
        WS_LOAD,
        WS_UPD1,
        WS_UPD2,
        WS_P1,
        WS_P2,
        WS_POS,
        WS_ALT,
        WS_EMPTY
    } t_wsel;

    typedef struct packed {
        logic    ld_in;
        t_rsel   rd_sel;
        logic    snap_rd;
        logic    snap_wr;
        t_wsel   wr_sel;
        logic    cnt_clr;
        logic    cnt_inc;
        logic    cur_from_rd;
        logic    chain_start;
        logic    ev_step;
        logic    ev_adv;
        logic    p_from_snap;
        logic    hold_save;
        logic    p_from_hold;
        logic    size_set;
        logic    size_inc;
        logic    out_load;
        t_status out_status;
    } t_cmd;

    typedef struct packed {
        t_action action;
        logic    m1;
        logic    m2;
        logic    e1;
        logic    e2;
        logic    key_empty;
        logic    rounds_over;
        logic    at_max;
        logic    cnt_last;
        logic    cnt_half_last;
        logic    snap_empty;
        logic    out_busy;
    } t_sts;

endpackage

### hw/rtl/cht_ctrl.sv
// cht_ctrl: sequencer for clear, load, read, insert, eviction chain and resize
// depends on cht_pkg; drives cht_dp through t_cmd, observes t_sts
module cht_ctrl
    import cht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_stall
);

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLR, ST_DISP, ST_IA, ST_IB, ST_IC, ST_EW, ST_EA, ST_ER,
        ST_GR, ST_GW, ST_GZ, ST_RR, ST_RD, ST_RN, ST_DONE
    } t_state;

    t_state  r_state, n_state;
    t_status r_status, n_status;
    logic    r_reins, n_reins;
    logic    r_boot, n_boot;
    logic    w_fin, w_fail;
    t_status w_res;

    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        o_cmd       = '0;
        o_cmd.rd_sel = RS_NONE;
        o_cmd.wr_sel = WS_NONE;
        o_cmd.out_status = r_status;
        n_state     = r_state;
        n_status    = r_status;
        n_reins     = r_reins;
        n_boot      = r_boot;
        w_fin       = 1'b0;
        w_fail      = 1'b0;
        w_res       = STS_INSERTED;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state = ST_DISP;
                end
            end
            ST_CLR: begin
                o_cmd.wr_sel = WS_EMPTY;
                if (i_sts.cnt_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_boot = 1'b0;
                    if (r_boot) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_DONE;
                        n_status = STS_OTHER;
                    end
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            ST_DISP: begin
                n_status = STS_OTHER;
                case (i_sts.action)
                    ACT_CLEAR: begin
                        o_cmd.size_set = 1'b1;
                        o_cmd.cnt_clr = 1'b1;
                        n_state = ST_CLR;
                    end
                    ACT_LOAD: begin
                        o_cmd.wr_sel = WS_LOAD;
                        n_state = ST_DONE;
                    end
                    ACT_INSERT: begin
                        n_reins = 1'b0;
                        if (i_sts.key_empty) begin
                            n_status = STS_FAILED;
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_IA;
                        end
                    end
                    default: begin
                        o_cmd.rd_sel = RS_IDX;
                        n_state = ST_DONE;
                    end
                endcase
            end
            ST_IA: begin
                o_cmd.rd_sel = RS_S1;
                n_state = ST_IB;
            end
            ST_IB: begin
                o_cmd.rd_sel = RS_S2;
                o_cmd.cur_from_rd = 1'b1;
                n_state = ST_IC;
            end
            ST_IC: begin
                if (i_sts.m1) begin
                    o_cmd.wr_sel = WS_UPD1;
                    w_fin = 1'b1;
                    w_res = STS_FOUND;
                end else if (i_sts.m2) begin
                    o_cmd.wr_sel = WS_UPD2;
                    w_fin = 1'b1;
                    w_res = STS_FOUND;
                end else if (i_sts.e1) begin
                    o_cmd.wr_sel = WS_P1;
                    w_fin = 1'b1;
                end else if (i_sts.e2) begin
                    o_cmd.wr_sel = WS_P2;
                    w_fin = 1'b1;
                end else begin
                    o_cmd.chain_start = 1'b1;
                    n_state = ST_EW;
                end
            end
            ST_EW: begin
                o_cmd.wr_sel = WS_POS;
                o_cmd.ev_step = 1'b1;
                n_state = ST_EA;
            end
            ST_EA: begin
                o_cmd.rd_sel = RS_ALT;
                n_state = ST_ER;
            end
            ST_ER: begin
                if (i_sts.e2) begin
                    o_cmd.wr_sel = WS_ALT;
                    w_fin = 1'b1;
                end else if (i_sts.rounds_over) begin
                    w_fail = 1'b1;
                end else begin
                    o_cmd.ev_adv = 1'b1;
                    n_state = ST_EW;
                end
            end
            ST_GR: begin
                o_cmd.rd_sel = RS_CNT;
                n_state = ST_GW;
            end
            ST_GW: begin
                o_cmd.snap_wr = 1'b1;
                if (i_sts.cnt_last) begin
                    o_cmd.size_inc = 1'b1;
                    o_cmd.cnt_clr = 1'b1;
                    n_state = ST_GZ;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = ST_GR;
                end
            end
            ST_GZ: begin
                o_cmd.wr_sel = WS_EMPTY;
                if (i_sts.cnt_last) begin
                    o_cmd.cnt_clr = 1'b1;
                    n_state = ST_RR;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                end
            end
            ST_RR: begin
                o_cmd.snap_rd = 1'b1;
                n_state = ST_RD;
            end
            ST_RD: begin
                if (i_sts.snap_empty) begin
                    n_state = ST_RN;
                end else begin
                    o_cmd.p_from_snap = 1'b1;
                    n_reins = 1'b1;
                    n_state = ST_IA;
                end
            end
            ST_RN: begin
                if (i_sts.cnt_half_last) begin
                    o_cmd.p_from_hold = 1'b1;
                    n_reins = 1'b0;
                    n_state = ST_IA;
                end else begin
                    o_cmd.cnt_inc = 1'b1;
                    n_state = ST_RR;
                end
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (w_fin) begin
            if (r_reins) begin
                n_state = ST_RN;
            end else begin
                n_state = ST_DONE;
                n_status = w_res;
            end
        end
        if (w_fail) begin
            if (r_reins) begin
                n_state = ST_RN;
            end else if (i_sts.at_max) begin
                n_state = ST_DONE;
                n_status = STS_FAILED;
            end else begin
                o_cmd.hold_save = 1'b1;
                o_cmd.cnt_clr = 1'b1;
                n_state = ST_GR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLR;
            r_status <= STS_OTHER;
            r_reins  <= 1'b0;
            r_boot   <= 1'b1;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
            r_reins  <= n_reins;
            r_boot   <= n_boot;
        end
    end

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> !i_sts.out_busy)
        else $error("result loaded while output held");

    a_grow_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.size_inc |-> !i_sts.at_max)
        else $error("table grown beyond maximum size");

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.ld_in |=> (r_state == ST_DISP))
        else $error("accepted item not dispatched");

endmodule

### hw/rtl/cht_dp.sv
// cht_dp: table and snapshot memories, pair registers, counters, result register
// depends on cht_pkg; controlled by cht_ctrl
module cht_dp
    import cht_pkg::*;
#(
    parameter int AW = 16,
    parameter int MAX_ROUNDS = 30,
    parameter int SECOND_SHIFT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_key,
    input  logic [31:0] i_key_hash,
    input  logic [31:0] i_value,
    input  logic [15:0] i_slot_index,
    input  logic [4:0]  i_new_size_log2,
    input  logic        i_stall,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [31:0] o_read_key,
    output logic [31:0] o_read_hash,
    output logic [31:0] o_read_value,
    output logic [4:0]  o_size_log2
);

    localparam int RW = $clog2(MAX_ROUNDS + 1);
    localparam int SW = (AW > 1) ? AW - 1 : 1;
    localparam int TD = 1 << AW;
    localparam int SD = 1 << (AW - 1);

    t_entry r_tbl [0:TD-1];
    t_entry r_snap [0:SD-1];

    t_action       r_act;
    logic [15:0]   r_slot;
    logic [4:0]    r_nsz;
    t_entry        r_p, r_hold, r_cur, r_rd, r_snap_rd;
    logic [AW-1:0] r_pos, r_alt;
    logic [RW-1:0] r_rounds;
    logic [AW:0]   r_cnt;
    logic [4:0]    r_size_log2;
    logic          r_ov;

    logic [AW:0]   w_size, w_size_m1, w_half_m1;
    logic [AW-1:0] w_mask, w_s1, w_s2, w_a1, w_a2, w_alt, w_idx;
    logic [31:0]   w_sh_p, w_sh_c, w_slot32;
    logic          w_re, w_we;
    logic [AW-1:0] w_raddr, w_waddr;
    t_entry        w_wdata;
    logic [4:0]    w_nsz_sat;

    assign w_size    = (AW+1)'(1) << r_size_log2;
    assign w_size_m1 = w_size - (AW+1)'(1);
    assign w_half_m1 = (w_size >> 1) - (AW+1)'(1);
    assign w_mask    = w_size_m1[AW-1:0];
    assign w_sh_p    = r_p.hash >> SECOND_SHIFT;
    assign w_sh_c    = r_cur.hash >> SECOND_SHIFT;
    assign w_s1      = r_p.hash[AW-1:0] & w_mask;
    assign w_s2      = w_sh_p[AW-1:0] & w_mask;
    assign w_a1      = r_cur.hash[AW-1:0] & w_mask;
    assign w_a2      = w_sh_c[AW-1:0] & w_mask;
    assign w_alt     = (w_a1 == r_pos) ? w_a2 : w_a1;
    assign w_slot32  = 32'(r_slot);
    assign w_idx     = w_slot32[AW-1:0] & w_mask;
    assign w_nsz_sat = (r_nsz > 5'(AW)) ? 5'(AW) : r_nsz;

    always_comb begin
        w_re = 1'b1;
        case (i_cmd.rd_sel)
            RS_IDX:  w_raddr = w_idx;
            RS_S1:   w_raddr = w_s1;
            RS_S2:   w_raddr = w_s2;
            RS_ALT:  w_raddr = r_alt;
            RS_CNT:  w_raddr = r_cnt[AW-1:0];
            default: begin
                w_raddr = r_cnt[AW-1:0];
                w_re = 1'b0;
            end
        endcase
    end

    always_comb begin
        w_we = 1'b1;
        w_waddr = r_cnt[AW-1:0];
        w_wdata = r_p;
        case (i_cmd.wr_sel)
            WS_LOAD: begin
                w_waddr = w_idx;
                if (r_p.key == EMPTY_KEY) begin
                    w_wdata = '{key: EMPTY_KEY, hash: 32'd0, value: 32'd0};
                end
            end
            WS_UPD1: begin
                w_waddr = w_s1;
                w_wdata = '{key: r_cur.key, hash: r_cur.hash, value: r_p.value};
            end
            WS_UPD2: begin
                w_waddr = w_s2;
                w_wdata = '{key: r_rd.key, hash: r_rd.hash, value: r_p.value};
            end
            WS_P1:   w_waddr = w_s1;
            WS_P2:   w_waddr = w_s2;
            WS_POS:  w_waddr = r_pos;
            WS_ALT:  w_waddr = r_alt;
            WS_EMPTY: begin
                w_wdata = '{key: EMPTY_KEY, hash: 32'd0, value: 32'd0};
            end
            default: w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_tbl[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd <= r_tbl[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.snap_wr) begin
            r_snap[r_cnt[SW-1:0]] <= r_rd;
        end
        if (i_cmd.snap_rd) begin
            r_snap_rd <= r_snap[r_cnt[SW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_act  <= t_action'(i_action);
            r_slot <= i_slot_index;
            r_nsz  <= i_new_size_log2;
            r_p    <= '{key: i_key, hash: i_key_hash, value: i_value};
        end else if (i_cmd.ev_step) begin
            r_p <= r_cur;
        end else if (i_cmd.p_from_snap) begin
            r_p <= r_snap_rd;
        end else if (i_cmd.p_from_hold) begin
            r_p <= r_hold;
        end
        if (i_cmd.hold_save) begin
            r_hold <= r_p;
        end
        if (i_cmd.cur_from_rd || i_cmd.ev_adv) begin
            r_cur <= r_rd;
        end
        if (i_cmd.ev_step) begin
            r_alt <= w_alt;
        end
        if (i_cmd.chain_start) begin
            r_pos    <= w_s1;
            r_rounds <= RW'(1);
        end else if (i_cmd.ev_adv) begin
            r_pos    <= r_alt;
            r_rounds <= r_rounds + RW'(1);
        end
        if (i_cmd.out_load) begin
            o_status    <= i_cmd.out_status;
            o_size_log2 <= r_size_log2;
            if (r_act == ACT_READ) begin
                o_read_key   <= r_rd.key;
                o_read_hash  <= r_rd.hash;
                o_read_value <= r_rd.value;
            end else begin
                o_read_key   <= 32'd0;
                o_read_hash  <= 32'd0;
                o_read_value <= 32'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_size_log2 <= 5'd0;
            r_ov        <= 1'b0;
        end else begin
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + (AW+1)'(1);
            end
            if (i_cmd.size_set) begin
                r_size_log2 <= w_nsz_sat;
            end else if (i_cmd.size_inc) begin
                r_size_log2 <= r_size_log2 + 5'd1;
            end
            if (i_cmd.out_load) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;

    assign o_sts.action        = r_act;
    assign o_sts.m1            = (r_cur.key == r_p.key);
    assign o_sts.m2            = (r_rd.key == r_p.key);
    assign o_sts.e1            = (r_cur.key == EMPTY_KEY);
    assign o_sts.e2            = (r_rd.key == EMPTY_KEY);
    assign o_sts.key_empty     = (r_p.key == EMPTY_KEY);
    assign o_sts.rounds_over   = (r_rounds >= RW'(MAX_ROUNDS));
    assign o_sts.at_max        = (r_size_log2 >= 5'(AW));
    assign o_sts.cnt_last      = (r_cnt == w_size_m1);
    assign o_sts.cnt_half_last = (r_cnt == w_half_m1);
    assign o_sts.snap_empty    = (r_snap_rd.key == EMPTY_KEY);
    assign o_sts.out_busy      = r_ov && i_stall;

endmodule

### hw/rtl/cuckoo_hash_insert_table.sv
// each eviction round swaps one slot and reads the alternate slot; a resize
// copies the n old entries to the snapshot, doubles the size, clears the table and
// reinserts the n old entries, then the held item; one item at a time
// reset: a one-entry clearing pass, table size one slot, no output pending
// top level of the cuckoo hash insert table; depends on cht_pkg, cht_ctrl, cht_dp
module cuckoo_hash_insert_table
    import cht_pkg::*;
#(
    parameter int MAX_SIZE_LOG2 = 16,
    parameter int MAX_ROUNDS = 30,
    parameter int SECOND_SHIFT = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_key,
    input  logic [31:0] i_key_hash,
    input  logic [31:0] i_value,
    input  logic [15:0] i_slot_index,
    input  logic [4:0]  i_new_size_log2,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_read_key,
    output logic [31:0] o_read_hash,
    output logic [31:0] o_read_value,
    output logic [4:0]  o_size_log2
);

    t_cmd w_cmd;
    t_sts w_sts;

    cht_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_stall (o_stall)
    );

    cht_dp #(
        .AW           (MAX_SIZE_LOG2),
        .MAX_ROUNDS   (MAX_ROUNDS),
        .SECOND_SHIFT (SECOND_SHIFT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_action        (i_action),
        .i_key           (i_key),
        .i_key_hash      (i_key_hash),
        .i_value         (i_value),
        .i_slot_index    (i_slot_index),
        .i_new_size_log2 (i_new_size_log2),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_read_key      (o_read_key),
        .o_read_hash     (o_read_hash),
        .o_read_value    (o_read_value),
        .o_size_log2     (o_size_log2)
    );

endmodule
